/* hw/rtl/bba_pkg.sv */
`default_nettype none

package bba_pkg;

    localparam int CNT_W = 13;
    localparam int IDX_W = 12;
    localparam logic [CNT_W-1:0] CNT_RESET = 13'd4096;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_RANGE        = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } t_status;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

endpackage

`default_nettype wire

/* hw/rtl/bba_if.sv */
`default_nettype none

interface bba_req_if import bba_pkg::*; ();
    logic             valid;
    logic             ready;
    t_cmd             cmd;
    logic [IDX_W-1:0] block_index;

    modport source (output valid, output cmd, output block_index, input ready);
    modport sink   (input valid, input cmd, input block_index, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
    logic             valid;
    logic             ready;
    t_status          status;
    logic [IDX_W-1:0] granted_index;

    modport source (output valid, output status, output granted_index, input ready);
    modport sink   (input valid, input status, input granted_index, output ready);
endinterface

`default_nettype wire

/* hw/rtl/block_bitmap_allocator.sv */
// Free: an accepted beat passes index split, read-check-write and output before the result beat.
// Allocate: bitmap words are scanned from the lowest word that may hold a
//   free bit, one word per cycle through the single read port of the bitmap RAM.
// One command in flight; the next beat is taken once the result sits in the output register.
// Reset (i_rst_n low, synchronous) starts a clearing pass over all ceil(MAX_BLOCKS / WORD_BITS)
//   words, zeroing the bitmap; no beat is taken meanwhile, block count returns to min(MAX_BLOCKS, 4096).
`default_nettype none

module block_bitmap_allocator import bba_pkg::*; #(
    parameter int MAX_BLOCKS = 4096,
    parameter int WORD_BITS  = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    bba_req_if.sink               i_req,
    bba_rsp_if.source             o_rsp,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_wdata
);

    localparam int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BW         = $clog2(MAX_BLOCKS + WORD_BITS + 1);
    localparam int PW         = $clog2(WORD_BITS);
    localparam int MAXB_W     = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W      = (CNT_W > MAXB_W) ? CNT_W : MAXB_W;
    localparam int CNT_MAX    = (2 ** CNT_W) - 1;
    localparam int EFF_MAX    = (MAX_BLOCKS < CNT_MAX) ? MAX_BLOCKS : CNT_MAX;
    localparam int EFF_W      = $clog2(EFF_MAX + 1);
    localparam int EFF_RST    = (MAX_BLOCKS < int'(CNT_RESET)) ? MAX_BLOCKS : int'(CNT_RESET);
    localparam int XW         = (IDX_W > EFF_W) ? IDX_W : EFF_W;
    localparam int DIV_S      = IDX_W + PW + 1;
    localparam int DIV_M      = (2 ** DIV_S) / WORD_BITS;
    localparam int PROD_W     = IDX_W + DIV_S;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_FREE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [EFF_W-1:0] r_eff, n_eff;
    logic [AW-1:0]    r_hint_addr, n_hint_addr;
    logic [BW-1:0]    r_hint_base, n_hint_base;
    logic [AW-1:0]    r_addr, n_addr;
    logic [BW-1:0]    r_base, n_base;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_q0, n_q0;
    logic [PW-1:0]    r_bit, n_bit;
    t_status          r_res_status, n_res_status;
    logic [IDX_W-1:0] r_res_index, n_res_index;
    logic             r_out_valid, n_out_valid;
    t_status          r_out_status, n_out_status;
    logic [IDX_W-1:0] r_out_index, n_out_index;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic                 ffz_found;
    logic [PW-1:0]        ffz_pos;
    logic [BW-1:0]        eff_ext;
    logic [BW-1:0]        lim;
    logic [BW-1:0]        next_base;
    logic [EFF_W-1:0]     cfg_eff;
    logic [PROD_W-1:0]    div_prod;
    logic [IDX_W-1:0]     rem0;
    logic [IDX_W-1:0]     rem;
    logic [IDX_W-1:0]     quo;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bba_ffz #(
        .WIDTH (WORD_BITS),
        .LIM_W (BW)
    ) u_ffz (
        .i_word  (ram_rdata),
        .i_lim   (lim),
        .o_found (ffz_found),
        .o_pos   (ffz_pos)
    );

    assign eff_ext   = BW'(r_eff);
    assign lim       = eff_ext - r_base;
    assign next_base = r_base + BW'(WORD_BITS);

    always_comb begin
        if (CMP_W'(i_cfg_wdata) > CMP_W'(MAX_BLOCKS)) begin
            cfg_eff = EFF_W'(MAX_BLOCKS);
        end else begin
            cfg_eff = EFF_W'(i_cfg_wdata);
        end
    end

    // index / WORD_BITS by reciprocal; quotient low by at most one
    assign div_prod = PROD_W'(i_req.block_index) * PROD_W'(DIV_M);
    assign rem0     = r_idx - IDX_W'(r_q0 * IDX_W'(WORD_BITS));

    always_comb begin
        if (rem0 >= IDX_W'(WORD_BITS)) begin
            rem = rem0 - IDX_W'(WORD_BITS);
            quo = r_q0 + IDX_W'(1);
        end else begin
            rem = rem0;
            quo = r_q0;
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.granted_index = r_out_index;

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_eff        = r_eff;
        n_hint_addr  = r_hint_addr;
        n_hint_base  = r_hint_base;
        n_addr       = r_addr;
        n_base       = r_base;
        n_idx        = r_idx;
        n_q0         = r_q0;
        n_bit        = r_bit;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        ram_we       = 1'b0;
        ram_waddr    = r_addr;
        ram_wdata    = ram_rdata;
        ram_raddr    = r_addr;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg_we) begin
            n_eff = cfg_eff;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(WORD_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_idx       = i_req.block_index;
                    n_q0        = div_prod[PROD_W-1:DIV_S];
                    n_res_index = '0;
                    if (i_req.cmd == CMD_ALLOC) begin
                        if (r_hint_base >= eff_ext) begin
                            n_res_status = ST_FULL;
                            n_state      = S_DONE;
                        end else begin
                            ram_raddr = r_hint_addr;
                            n_addr    = r_hint_addr;
                            n_base    = r_hint_base;
                            n_state   = S_SCAN;
                        end
                    end else begin
                        if (XW'(i_req.block_index) >= XW'(r_eff)) begin
                            n_res_status = ST_RANGE;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                ram_raddr = AW'(quo);
                n_addr    = AW'(quo);
                n_base    = BW'(r_idx - rem);
                n_bit     = PW'(rem);
                n_state   = S_FREE;
            end
            S_FREE: begin
                if (!ram_rdata[r_bit]) begin
                    n_res_status = ST_ALREADY_FREE;
                end else begin
                    ram_we       = 1'b1;
                    ram_wdata    = ram_rdata & ~(WORD_BITS'(1) << r_bit);
                    n_res_status = ST_OK;
                    if (r_addr < r_hint_addr) begin
                        n_hint_addr = r_addr;
                        n_hint_base = r_base;
                    end
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (ffz_found) begin
                    ram_we       = 1'b1;
                    ram_wdata    = ram_rdata | (WORD_BITS'(1) << ffz_pos);
                    n_res_status = ST_OK;
                    n_res_index  = IDX_W'(r_base + BW'(ffz_pos));
                    n_hint_addr  = r_addr;
                    n_hint_base  = r_base;
                    n_state      = S_DONE;
                end else if (next_base >= eff_ext) begin
                    n_res_status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    ram_raddr = r_addr + AW'(1);
                    n_addr    = r_addr + AW'(1);
                    n_base    = next_base;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_index  = r_res_index;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_base       <= n_base;
        r_idx        <= n_idx;
        r_q0         <= n_q0;
        r_bit        <= n_bit;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_eff       <= EFF_W'(EFF_RST);
            r_hint_addr <= '0;
            r_hint_base <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_eff       <= n_eff;
            r_hint_addr <= n_hint_addr;
            r_hint_base <= n_hint_base;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/bba_ram.sv */
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/bba_ffz.sv */
`default_nettype none

// lowest clear bit among positions below i_lim
module bba_ffz #(
    parameter int WIDTH = 32,
    parameter int LIM_W = 13
) (
    input  wire logic [WIDTH-1:0]         i_word,
    input  wire logic [LIM_W-1:0]         i_lim,
    output logic                          o_found,
    output logic [$clog2(WIDTH)-1:0]      o_pos
);

    localparam int PW = $clog2(WIDTH);

    logic [WIDTH-1:0] cand;

    always_comb begin
        for (int b = 0; b < WIDTH; b++) begin
            cand[b] = !i_word[b] && (LIM_W'(b) < i_lim);
        end
    end

    always_comb begin
        o_pos = '0;
        for (int b = WIDTH - 1; b >= 0; b--) begin
            if (cand[b]) begin
                o_pos = PW'(b);
            end
        end
    end

    assign o_found = |cand;

endmodule

`default_nettype wire

/* hw/rtl/bba_chk.sv */
`default_nettype none

module bba_chk import bba_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_req_valid,
    input wire logic             i_req_ready,
    input wire logic             i_rsp_valid,
    input wire logic             i_rsp_ready,
    input wire t_status          i_rsp_status,
    input wire logic [IDX_W-1:0] i_rsp_granted_index
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_granted_index))
        else $error("result beat changed while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != ST_OK) |-> i_rsp_granted_index == '0)
        else $error("failed command carries a nonzero index");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready && !i_rsp_valid)
        else $error("activity right after reset");

    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second beat taken while a command is in flight");

endmodule

bind block_bitmap_allocator bba_chk u_bba_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_status        (o_rsp.status),
    .i_rsp_granted_index (o_rsp.granted_index)
);

`default_nettype wire
